// File: rtl/core/lsfs_pkg.sv
// shared constants, payload types and codes for the led strip frame streamer
package lsfs_pkg;

    // image geometry
    localparam int POS_COUNT    = 64;
    localparam int FINS         = 2;
    localparam int LEDS_ON_FIN  = 6;
    localparam int LEDS_PER_POS = FINS * LEDS_ON_FIN;
    localparam int STORE_DEPTH  = POS_COUNT * LEDS_PER_POS;
    localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LED_W        = (LEDS_PER_POS > 1) ? $clog2(LEDS_PER_POS) : 1;

    // frame layout
    localparam int          BORDER_BYTES = 4;
    localparam int          CNT_W        = $clog2(BORDER_BYTES);
    localparam logic [7:0]  BYTE_START   = 8'h00;
    localparam logic [7:0]  BYTE_END     = 8'hFF;
    localparam logic [7:0]  LED_HEADER   = 8'hE0;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register port
    localparam int          PADDR_W               = 3;
    localparam int          APB_DATA_W            = 32;
    localparam int          BRIGHT_W              = 5;
    localparam logic [4:0]  BRIGHT_RESET          = 5'd31;
    localparam logic [0:0]  REG_GLOBAL_BRIGHTNESS = 1'b0;

    typedef enum logic [0:0] {
        CMD_WRITE    = 1'b0,
        CMD_TRANSMIT = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [5:0] pos_index;
        logic [0:0] fin_index;
        logic [2:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic [0:0] last_byte;
    } t_result;

    typedef struct packed {
        logic [BRIGHT_W-1:0] bright;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
    } t_led_entry;

    // classified job: store address, range flag and the entry to write
    typedef struct packed {
        t_cmd              cmd;
        logic              ok;
        logic [ADDR_W-1:0] addr;
        t_led_entry        entry;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_LED,
        ST_END
    } t_back_state;

endpackage

// File: rtl/core/lsfs_front.sv
// front end: register port, command acceptance and classification
module lsfs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [lsfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lsfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  lsfs_pkg::t_item               i_item,
    input  lsfs_pkg::t_queue_status       i_status,
    output logic                          o_push,
    output lsfs_pkg::t_job                o_job
);
    import lsfs_pkg::*;

    logic [BRIGHT_W-1:0] r_bright;
    logic                reg_hit;
    logic                pos_ok;
    logic                wr_ok;
    logic [15:0]         addr_calc;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_GLOBAL_BRIGHTNESS);

    // brightness register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= BRIGHT_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_bright <= pwdata[BRIGHT_W-1:0];
        end
    end

    // register read back
    assign prdata = reg_hit ? APB_DATA_W'(r_bright) : '0;

    // range checks and store address
    always_comb begin
        pos_ok = (16'(i_item.pos_index) < 16'(POS_COUNT));
        wr_ok  = pos_ok && (16'(i_item.fin_index) < 16'(FINS))
                 && (16'(i_item.led_index) < 16'(LEDS_ON_FIN));
        if (i_item.cmd == CMD_WRITE) begin
            addr_calc = 16'(i_item.pos_index) * 16'(LEDS_PER_POS)
                        + 16'(i_item.fin_index) * 16'(LEDS_ON_FIN)
                        + 16'(i_item.led_index);
        end else begin
            addr_calc = 16'(i_item.pos_index) * 16'(LEDS_PER_POS);
        end
    end

    // job for the queue; bad writes are dropped here
    always_comb begin
        o_job.cmd          = i_item.cmd;
        o_job.ok           = (i_item.cmd == CMD_WRITE) ? wr_ok : pos_ok;
        o_job.addr         = o_job.ok ? addr_calc[ADDR_W-1:0] : '0;
        o_job.entry.bright = r_bright;
        o_job.entry.red    = i_item.red;
        o_job.entry.green  = i_item.green;
        o_job.entry.blue   = i_item.blue;
    end

    assign busy   = i_status.full;
    assign o_push = start && !busy && ((i_item.cmd == CMD_TRANSMIT) || wr_ok);

endmodule

// File: rtl/core/lsfs_queue.sv
// short job queue between the front and back ends
module lsfs_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  lsfs_pkg::t_job          i_job,
    input  logic                    i_pop,
    output lsfs_pkg::t_job          o_head,
    output lsfs_pkg::t_queue_status o_status
);
    import lsfs_pkg::*;

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_slot[r_rd_ptr];

    // payload slots
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/lsfs_back.sv
// back end: led store and frame byte sequencer
module lsfs_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lsfs_pkg::t_job          i_head,
    input  lsfs_pkg::t_queue_status i_status,
    output logic                    o_pop,
    output logic                    o_strobe,
    output lsfs_pkg::t_result       o_result
);
    import lsfs_pkg::*;

    localparam logic [1:0] PH_BRIGHT = 2'd0;
    localparam logic [1:0] PH_RED    = 2'd1;
    localparam logic [1:0] PH_BLUE   = 2'd2;
    localparam logic [1:0] PH_GREEN  = 2'd3;

    t_led_entry        r_mem [STORE_DEPTH];
    t_led_entry        r_rd;
    t_back_state       r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]        r_phase, n_phase;
    logic [LED_W-1:0]  r_led, n_led;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_ok, n_ok;
    logic              r_strobe, n_strobe;
    logic [7:0]        r_byte, n_byte;
    logic              r_last, n_last;
    logic              mem_we;
    logic              rd_en;
    t_led_entry        cur;

    // led store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_head.addr] <= i_head.entry;
        end
        if (rd_en) begin
            r_rd <= r_mem[r_addr];
        end
    end

    // out-of-range positions read as a blank led
    assign cur = r_ok ? r_rd : '0;

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_phase  <= '0;
            r_led    <= '0;
            r_addr   <= '0;
            r_ok     <= 1'b0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_phase  <= n_phase;
            r_led    <= n_led;
            r_addr   <= n_addr;
            r_ok     <= n_ok;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    // output byte register
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    // next state and byte selection
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_phase  = r_phase;
        n_led    = r_led;
        n_addr   = r_addr;
        n_ok     = r_ok;
        n_strobe = 1'b0;
        n_byte   = BYTE_START;
        n_last   = 1'b0;
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        rd_en    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_status.empty) begin
                    o_pop = 1'b1;
                    if (i_head.cmd == CMD_TRANSMIT) begin
                        n_addr  = i_head.addr;
                        n_ok    = i_head.ok;
                        n_cnt   = '0;
                        n_state = ST_START;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
            end
            ST_START: begin
                n_strobe = 1'b1;
                n_byte   = BYTE_START;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(BORDER_BYTES - 1)) begin
                    // fetch the first led ahead of its header byte
                    rd_en   = 1'b1;
                    n_addr  = r_addr + 1'b1;
                    n_led   = '0;
                    n_phase = PH_BRIGHT;
                    n_state = ST_LED;
                end
            end
            ST_LED: begin
                n_strobe = 1'b1;
                n_phase  = r_phase + 1'b1;
                case (r_phase)
                    PH_BRIGHT: n_byte = LED_HEADER | 8'(cur.bright);
                    PH_RED:    n_byte = cur.red;
                    PH_BLUE:   n_byte = cur.blue;
                    PH_GREEN:  n_byte = cur.green;
                    default:   n_byte = cur.green;
                endcase
                if (r_phase == PH_GREEN) begin
                    if (r_led == LED_W'(LEDS_PER_POS - 1)) begin
                        n_cnt   = '0;
                        n_state = ST_END;
                    end else begin
                        // fetch the next led while this one finishes
                        rd_en  = 1'b1;
                        n_addr = r_addr + 1'b1;
                        n_led  = r_led + 1'b1;
                    end
                end
            end
            ST_END: begin
                n_strobe = 1'b1;
                n_byte   = BYTE_END;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(BORDER_BYTES - 1)) begin
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_strobe           = r_strobe;
    assign o_result.tx_byte   = r_byte;
    assign o_result.last_byte = r_last;

endmodule

// File: rtl/core/led_strip_frame_streamer.sv
// top level of the led strip frame streamer
// A write command (cmd 0) stores one LED's color with the current global brightness and
// produces no output; the back end stores it without leaving its idle state. A transmit
// command (cmd 1) sends the frame for one position: 4 bytes of 0x00, then per LED the header
// (brightness | 0xE0), red, blue and green, then 4 bytes of 0xFF with last_byte set on
// the final one, i.e. 8 + 4*FINS*LEDS_ON_FIN bytes (56 by default). The back-end
// sequencer emits one byte per cycle on o_strobe/o_result during a frame; an accepted
// transmit passes through the queue, the sequencer state and the output byte register
// before its first byte appears, and consecutive frames are separated by an idle gap. Output
// bytes cannot be held off. A two-entry queue decouples acceptance from the sequencer:
// busy is high only while that queue is full. The LED store has no reset and no clearing
// pass: every entry must be written before its position is transmitted. Writes with an
// out-of-range index are dropped; an out-of-range position transmits blank LEDs.
module led_strip_frame_streamer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsfs_pkg::PADDR_W-1:0]    paddr,
    input  logic [lsfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lsfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  lsfs_pkg::t_item                 i_item,
    output logic                            o_strobe,
    output lsfs_pkg::t_result               o_result
);
    import lsfs_pkg::*;

    t_job          push_job;
    t_job          head_job;
    t_queue_status status;
    logic          push;
    logic          pop;

    // command acceptance and register port
    lsfs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .i_status (status),
        .o_push   (push),
        .o_job    (push_job)
    );

    // job queue
    lsfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (status)
    );

    // store and frame sequencer
    lsfs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_job),
        .i_status (status),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// File: rtl/core/lsfs_checker.sv
// port-level checks on the frame byte stream, bound to the top level
module lsfs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_strobe,
    input lsfs_pkg::t_result   o_result
);
    import lsfs_pkg::*;

    // last flag only on a strobed byte
    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.last_byte |-> o_strobe)
        else $error("last_byte without strobe");

    // final byte of a frame is an end byte
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_byte) |-> (o_result.tx_byte == BYTE_END))
        else $error("last byte is not an end byte");

    // every frame opens with a start byte
    a_first_is_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> (o_result.tx_byte == BYTE_START))
        else $error("frame does not open with a start byte");

    // a gap follows the end of each frame
    a_gap_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_byte) |=> !o_strobe)
        else $error("no gap after last byte");

endmodule

bind led_strip_frame_streamer lsfs_checker u_lsfs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// File: verif/led_strip_frame_streamer_test.sv
// self-checking testbench for the led strip frame streamer: directed frames, then random fills
module led_strip_frame_streamer_test;
    import lsfs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 180;
    localparam int NUM_PHASES   = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int DIR_ROWS     = 18;
    localparam logic [PADDR_W-1:0] BRIGHT_ADDR = PADDR_W'(4 * REG_GLOBAL_BRIGHTNESS);
    localparam logic [PADDR_W-1:0] SPARE_ADDR  = PADDR_W'(4 * (REG_GLOBAL_BRIGHTNESS + 1));

    // one row of the directed table; led_hdr and led_val give every led byte of the frame when typed is set
    typedef struct {
        t_item      item;
        logic       typed;
        logic [7:0] led_hdr;
        logic [7:0] led_val;
    } t_dir_row;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_W-1:0]    paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start   = 1'b0;
    logic                  busy;
    t_item                 i_item  = '0;
    logic                  o_strobe;
    t_result               o_result;

    // image copy and register copy used for prediction
    t_led_entry          led_image [STORE_DEPTH];
    bit                  led_written [STORE_DEPTH];
    logic [BRIGHT_W-1:0] bright_cfg = BRIGHT_RESET;
    t_result             tx_bytes_due [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int n_accepted  = 0;
    int n_writes    = 0;
    int n_dropped   = 0;
    int n_frames    = 0;
    int n_checked   = 0;

    led_strip_frame_streamer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
                     tx_bytes_due.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    function automatic t_result frame_byte(input logic [7:0] value, input logic last);
        t_result r;
        r.tx_byte   = value;
        r.last_byte = last;
        return r;
    endfunction

    function automatic t_item make_item(input t_cmd cmd, input logic [5:0] pos,
                                        input logic [0:0] fin, input logic [2:0] led,
                                        input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        t_item it;
        it.cmd       = cmd;
        it.pos_index = pos;
        it.fin_index = fin;
        it.led_index = led;
        it.red       = r;
        it.green     = g;
        it.blue      = b;
        return it;
    endfunction

    function automatic t_dir_row dir_row(input t_cmd cmd, input int pos, input int fin,
                                         input int led, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b,
                                         input logic typed, input logic [7:0] hdr,
                                         input logic [7:0] val);
        t_dir_row row;
        row.item    = make_item(cmd, 6'(pos), 1'(fin), 3'(led), r, g, b);
        row.typed   = typed;
        row.led_hdr = hdr;
        row.led_val = val;
        return row;
    endfunction

    // transmit command with junk in the fields it does not use
    function automatic t_item frame_cmd(input logic [5:0] pos);
        return make_item(CMD_TRANSMIT, pos, 1'($urandom), 3'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
    endfunction

    function automatic logic [7:0] rand_color();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] rand_pos();
        case ($urandom_range(3))
            0: return 6'd0;
            1: return 6'(POS_COUNT - 1);
            default: return 6'($urandom_range(POS_COUNT - 1));
        endcase
    endfunction

    // bytes of one frame: start border, four bytes per led, end border with the last flag
    task automatic expect_frame(input logic [5:0] pos, input logic typed,
                                input logic [7:0] hdr, input logic [7:0] val);
        t_led_entry e;
        int         n;
        for (n = 0; n < BORDER_BYTES; n++)
            tx_bytes_due.push_back(frame_byte(BYTE_START, 1'b0));
        for (n = 0; n < LEDS_PER_POS; n++) begin
            e = (int'(pos) < POS_COUNT) ? led_image[int'(pos) * LEDS_PER_POS + n] : '0;
            if (typed) begin
                tx_bytes_due.push_back(frame_byte(hdr, 1'b0));
                repeat (3) tx_bytes_due.push_back(frame_byte(val, 1'b0));
            end else begin
                tx_bytes_due.push_back(frame_byte(LED_HEADER | 8'(e.bright), 1'b0));
                tx_bytes_due.push_back(frame_byte(e.red, 1'b0));
                tx_bytes_due.push_back(frame_byte(e.blue, 1'b0));
                tx_bytes_due.push_back(frame_byte(e.green, 1'b0));
            end
        end
        for (n = 0; n < BORDER_BYTES; n++)
            tx_bytes_due.push_back(frame_byte(BYTE_END, n == BORDER_BYTES - 1));
    endtask

    // update the image copy or queue the frame for one accepted command
    task automatic apply_command(input t_item it, input logic typed, input logic [7:0] hdr,
                                 input logic [7:0] val);
        int idx;
        if (it.cmd == CMD_WRITE) begin
            if (int'(it.pos_index) < POS_COUNT && int'(it.fin_index) < FINS &&
                int'(it.led_index) < LEDS_ON_FIN) begin
                idx = (int'(it.pos_index) * FINS + int'(it.fin_index)) * LEDS_ON_FIN
                      + int'(it.led_index);
                led_image[idx].bright = bright_cfg;
                led_image[idx].red    = it.red;
                led_image[idx].green  = it.green;
                led_image[idx].blue   = it.blue;
                led_written[idx]      = 1'b1;
                n_writes++;
                n_accepted++;
            end else begin
                n_dropped++;
                n_accepted++;
            end
        end else begin
            expect_frame(it.pos_index, typed, hdr, val);
            n_frames++;
            n_accepted++;
        end
    endtask

    // drive one command transaction, then maybe a burst of idle cycles
    task automatic issue(input t_item it, input int idle_pct, input logic typed,
                         input logic [7:0] hdr, input logic [7:0] val);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        apply_command(it, typed, hdr, val);
        if ($urandom_range(99) < idle_pct) begin
            start  <= 1'b0;
            i_item <= $bits(t_item)'({$urandom, $urandom});
            repeat ($urandom_range(14, 1)) @(posedge i_clk);
        end
    endtask

    // wait for all frames to finish plus the trailing writes still in the queue
    task automatic wait_drained();
        start <= 1'b0;
        while (tx_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register port transaction: setup cycle, then access until pready
    task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_brightness();
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b0, BRIGHT_ADDR, '0, rd);
        if (rd[BRIGHT_W-1:0] !== bright_cfg)
            note_mismatch($sformatf("global_brightness read exp %0d got %0d",
                                    bright_cfg, rd[BRIGHT_W-1:0]));
    endtask

    task automatic set_brightness(input logic [BRIGHT_W-1:0] value);
        logic [APB_DATA_W-1:0] wd;
        logic [APB_DATA_W-1:0] rd;
        // a write to the unused address must leave the register alone
        apb_xfer(1'b1, SPARE_ADDR, APB_DATA_W'($urandom), rd);
        wd                = APB_DATA_W'($urandom);
        wd[BRIGHT_W-1:0]  = value;
        apb_xfer(1'b1, BRIGHT_ADDR, wd, rd);
        bright_cfg = value;
        check_brightness();
    endtask

    // well-formed sequence: write every led of one position in random order, then send it
    task automatic fill_position(input int idle_pct);
        int         order [LEDS_PER_POS];
        int         n;
        int         j;
        int         tmp;
        logic [5:0] pos;
        pos = rand_pos();
        for (n = 0; n < LEDS_PER_POS; n++)
            order[n] = n;
        for (n = LEDS_PER_POS - 1; n > 0; n--) begin
            j        = $urandom_range(n);
            tmp      = order[n];
            order[n] = order[j];
            order[j] = tmp;
        end
        for (n = 0; n < LEDS_PER_POS; n++) begin
            // now and then a write aimed past the last led of a fin
            if ($urandom_range(5) == 0)
                issue(make_item(CMD_WRITE, rand_pos(), 1'($urandom),
                                3'($urandom_range(7, LEDS_ON_FIN)), rand_color(),
                                rand_color(), rand_color()), idle_pct, 1'b0, 8'h00, 8'h00);
            issue(make_item(CMD_WRITE, pos, 1'(order[n] / LEDS_ON_FIN),
                            3'(order[n] % LEDS_ON_FIN), rand_color(), rand_color(),
                            rand_color()), idle_pct, 1'b0, 8'h00, 8'h00);
        end
        issue(frame_cmd(pos), idle_pct, 1'b0, 8'h00, 8'h00);
    endtask

    // loose writes anywhere, then a frame from some fully written position
    task automatic touch_and_send(input int idle_pct);
        logic [5:0] ready_q [$];
        int         n;
        int         k;
        bit         full;
        repeat ($urandom_range(4, 1))
            issue(make_item(CMD_WRITE, rand_pos(), 1'($urandom), 3'($urandom), rand_color(),
                            rand_color(), rand_color()), idle_pct, 1'b0, 8'h00, 8'h00);
        for (n = 0; n < POS_COUNT; n++) begin
            full = 1'b1;
            for (k = 0; k < LEDS_PER_POS; k++)
                if (!led_written[n * LEDS_PER_POS + k])
                    full = 1'b0;
            if (full)
                ready_q.push_back(6'(n));
        end
        if (ready_q.size() != 0)
            issue(frame_cmd(ready_q[$urandom_range(ready_q.size() - 1)]), idle_pct, 1'b0,
                  8'h00, 8'h00);
    endtask

    // byte monitor: each strobe is compared with the oldest byte due
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            n_checked++;
            if (tx_bytes_due.size() == 0) begin
                note_mismatch($sformatf("byte %h last %b with nothing due",
                                        o_result.tx_byte, o_result.last_byte));
            end else begin
                want = tx_bytes_due.pop_front();
                if (o_result.tx_byte !== want.tx_byte)
                    note_mismatch($sformatf("tx_byte exp %h got %h", want.tx_byte,
                                            o_result.tx_byte));
                if (o_result.last_byte !== want.last_byte)
                    note_mismatch($sformatf("last_byte exp %b got %b (byte %h)",
                                            want.last_byte, o_result.last_byte,
                                            want.tx_byte));
            end
        end
    end

    // stimulus
    initial begin
        t_dir_row            dir_tab [DIR_ROWS];
        int                  row;
        int                  ph;
        int                  idle_pct;
        int                  phase_mark;
        logic [BRIGHT_W-1:0] level;

        // position 63 filled white at reset brightness, so every led byte of its frame is 0xFF
        dir_tab[0]  = dir_row(CMD_WRITE, 63, 0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[1]  = dir_row(CMD_WRITE, 63, 0, 1, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[2]  = dir_row(CMD_WRITE, 63, 0, 2, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[3]  = dir_row(CMD_WRITE, 63, 0, 3, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[4]  = dir_row(CMD_WRITE, 63, 0, 4, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[5]  = dir_row(CMD_WRITE, 63, 0, 5, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[6]  = dir_row(CMD_WRITE, 63, 1, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[7]  = dir_row(CMD_WRITE, 63, 1, 1, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[8]  = dir_row(CMD_WRITE, 63, 1, 2, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[9]  = dir_row(CMD_WRITE, 63, 1, 3, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[10] = dir_row(CMD_WRITE, 63, 1, 4, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[11] = dir_row(CMD_WRITE, 63, 1, 5, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
        // led index past the fin: dropped, the frame stays white
        dir_tab[12] = dir_row(CMD_WRITE, 63, 1, 6, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
        dir_tab[13] = dir_row(CMD_WRITE, 63, 0, 7, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
        dir_tab[14] = dir_row(CMD_TRANSMIT, 63, 1, 7, 8'h5A, 8'hA5, 8'h3C, 1'b1, 8'hFF, 8'hFF);
        // black first led and distinct colors on the last to catch byte order
        dir_tab[15] = dir_row(CMD_WRITE, 63, 0, 0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
        dir_tab[16] = dir_row(CMD_WRITE, 63, 1, 5, 8'h12, 8'h34, 8'h56, 1'b0, 8'h00, 8'h00);
        dir_tab[17] = dir_row(CMD_TRANSMIT, 63, 0, 0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_brightness();

        // directed part
        for (row = 0; row < DIR_ROWS; row++)
            issue(dir_tab[row].item, 30, dir_tab[row].typed, dir_tab[row].led_hdr,
                  dir_tab[row].led_val);

        // random part, one brightness setting per phase, no idling in the last one
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: level = '0;
                2: level = '1;
                default: level = BRIGHT_W'($urandom);
            endcase
            set_brightness(level);
            if (ph == NUM_PHASES - 1 || $urandom_range(3) == 0)
                idle_pct = 0;
            else
                idle_pct = $urandom_range(50, 10);
            phase_mark = n_accepted;
            while (n_accepted - phase_mark < RANDOM_ITEMS / NUM_PHASES) begin
                if ($urandom_range(9) < 6)
                    fill_position(idle_pct);
                else
                    touch_and_send(idle_pct);
            end
        end
        wait_drained();

        $display("covered %0d led writes, %0d dropped writes and %0d frames over %0d phases",
                 n_writes, n_dropped, n_frames, NUM_PHASES);
        $display("checked %0d output bytes, %0d mismatches", n_checked, mismatches);
        if (mismatches == 0 && tx_bytes_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
